// File: hw/rtl/estmf_pkg.sv
// Shared types, constants, microcode program and helper functions of the speed filter.
`default_nettype none

package estmf_pkg;

  // Window geometry
  localparam int WINDOW_SIZE   = 10;
  localparam int TRIM_EACH_END = 2;
  localparam int KEEP_COUNT    = WINDOW_SIZE - 2 * TRIM_EACH_END;
  localparam int WIN_IW        = $clog2(WINDOW_SIZE);

  // Sum of the window, digit-serial divider sizing
  localparam int SUM_W      = 33 + $clog2(WINDOW_SIZE);
  localparam int DIV_DIGITS = (SUM_W + 3) / 4;
  localparam int DIV_W      = 4 * DIV_DIGITS;

  // Arithmetic widths
  localparam int PROD_W  = 64;
  localparam int RND_W   = 48;
  localparam int MUL_W   = 50;
  localparam int ONE_Q16 = 65536;

  // Sequencer sizing
  localparam int CNT_W  = 4;
  localparam int STEP_W = 4;

  localparam logic [WIN_IW-1:0] FILL_LAST = WIN_IW'(WINDOW_SIZE - 1);
  localparam logic [CNT_W-1:0]  SCAN_LAST = CNT_W'(WINDOW_SIZE - 1);
  localparam logic [CNT_W-1:0]  DIV_LAST  = CNT_W'(DIV_DIGITS - 1);

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_SAMPLE_PERIOD = 2'd0,
    REG_RPM_GAIN      = 2'd1,
    REG_FILTER_ALPHA  = 2'd2
  } reg_idx_t;

  // Datapath operations, one per microcode step
  typedef enum logic [3:0] {
    OP_ACCEPT    = 4'd0,
    OP_MUL_LO    = 4'd1,
    OP_MUL_HI    = 4'd2,
    OP_ROUND     = 4'd3,
    OP_STORE     = 4'd4,
    OP_SCAN_INIT = 4'd5,
    OP_SCAN      = 4'd6,
    OP_TRIM_LO   = 4'd7,
    OP_TRIM_HI   = 4'd8,
    OP_ABS       = 4'd9,
    OP_DIV       = 4'd10,
    OP_AVG       = 4'd11,
    OP_FMUL_NEW  = 4'd12,
    OP_FMUL_OLD  = 4'd13,
    OP_FROUND    = 4'd14,
    OP_EMIT      = 4'd15
  } op_t;

  // Handshake a step waits on
  typedef enum logic [1:0] {
    WT_NONE = 2'd0,
    WT_IN   = 2'd1,
    WT_OUT  = 2'd2
  } wait_t;

  // Jump conditions
  typedef enum logic [2:0] {
    JC_NEXT      = 3'd0,
    JC_ALWAYS    = 3'd1,
    JC_NO_SAMPLE = 3'd2,
    JC_NOT_FULL  = 3'd3,
    JC_SCAN_MORE = 3'd4,
    JC_DIV_MORE  = 3'd5
  } jcond_t;

  // Program addresses
  localparam logic [STEP_W-1:0] ST_ACCEPT    = 4'd0;
  localparam logic [STEP_W-1:0] ST_MUL_LO    = 4'd1;
  localparam logic [STEP_W-1:0] ST_MUL_HI    = 4'd2;
  localparam logic [STEP_W-1:0] ST_ROUND     = 4'd3;
  localparam logic [STEP_W-1:0] ST_STORE     = 4'd4;
  localparam logic [STEP_W-1:0] ST_SCAN_INIT = 4'd5;
  localparam logic [STEP_W-1:0] ST_SCAN      = 4'd6;
  localparam logic [STEP_W-1:0] ST_TRIM_LO   = 4'd7;
  localparam logic [STEP_W-1:0] ST_TRIM_HI   = 4'd8;
  localparam logic [STEP_W-1:0] ST_ABS       = 4'd9;
  localparam logic [STEP_W-1:0] ST_DIV       = 4'd10;
  localparam logic [STEP_W-1:0] ST_AVG       = 4'd11;
  localparam logic [STEP_W-1:0] ST_FMUL_NEW  = 4'd12;
  localparam logic [STEP_W-1:0] ST_FMUL_OLD  = 4'd13;
  localparam logic [STEP_W-1:0] ST_FROUND    = 4'd14;
  localparam logic [STEP_W-1:0] ST_EMIT      = 4'd15;

  // One control word
  typedef struct packed {
    op_t               op;
    wait_t             wt;
    jcond_t            jc;
    logic [STEP_W-1:0] target;
  } ucw_t;

  // Status from the datapath to the sequencer
  typedef struct packed {
    logic sample_due;
    logic not_full;
    logic scan_more;
    logic div_more;
    logic out_free;
  } dp_flags_t;

  // Control from the sequencer to the datapath
  typedef struct packed {
    op_t  op;
    logic fire;
  } seq_ctrl_t;

  // Quotient and remainder of one divider digit
  typedef struct packed {
    logic [3:0] q;
    logic [3:0] r;
  } digit_t;

  // Microcode program
  function automatic ucw_t ucode(input logic [STEP_W-1:0] step);
    ucw_t w;
    unique case (step)
      ST_ACCEPT:    w = '{OP_ACCEPT,    WT_IN,   JC_NO_SAMPLE, ST_EMIT};
      ST_MUL_LO:    w = '{OP_MUL_LO,    WT_NONE, JC_NEXT,      ST_ACCEPT};
      ST_MUL_HI:    w = '{OP_MUL_HI,    WT_NONE, JC_NEXT,      ST_ACCEPT};
      ST_ROUND:     w = '{OP_ROUND,     WT_NONE, JC_NEXT,      ST_ACCEPT};
      ST_STORE:     w = '{OP_STORE,     WT_NONE, JC_NOT_FULL,  ST_EMIT};
      ST_SCAN_INIT: w = '{OP_SCAN_INIT, WT_NONE, JC_NEXT,      ST_ACCEPT};
      ST_SCAN:      w = '{OP_SCAN,      WT_NONE, JC_SCAN_MORE, ST_SCAN};
      ST_TRIM_LO:   w = '{OP_TRIM_LO,   WT_NONE, JC_NEXT,      ST_ACCEPT};
      ST_TRIM_HI:   w = '{OP_TRIM_HI,   WT_NONE, JC_NEXT,      ST_ACCEPT};
      ST_ABS:       w = '{OP_ABS,       WT_NONE, JC_NEXT,      ST_ACCEPT};
      ST_DIV:       w = '{OP_DIV,       WT_NONE, JC_DIV_MORE,  ST_DIV};
      ST_AVG:       w = '{OP_AVG,       WT_NONE, JC_NEXT,      ST_ACCEPT};
      ST_FMUL_NEW:  w = '{OP_FMUL_NEW,  WT_NONE, JC_NEXT,      ST_ACCEPT};
      ST_FMUL_OLD:  w = '{OP_FMUL_OLD,  WT_NONE, JC_NEXT,      ST_ACCEPT};
      ST_FROUND:    w = '{OP_FROUND,    WT_NONE, JC_NEXT,      ST_ACCEPT};
      ST_EMIT:      w = '{OP_EMIT,      WT_OUT,  JC_ALWAYS,    ST_ACCEPT};
      default:      w = '{OP_ACCEPT,    WT_IN,   JC_NO_SAMPLE, ST_EMIT};
    endcase
    return w;
  endfunction

  // One radix-16 digit of a division by the kept sample count
  function automatic digit_t div_digit(input logic [7:0] v);
    digit_t d;
    logic [3:0] q;
    q = 4'd0;
    for (int k = 1; k < 16; k++) begin
      if (32'(v) >= 32'(k * KEEP_COUNT)) q = 4'(k);
    end
    d.q = q;
    d.r = 4'(v - 8'(q * KEEP_COUNT));
    return d;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/estmf_sequencer.sv
// Microcode sequencer: step counter, program lookup, waits and conditional jumps.
`default_nettype none

module estmf_sequencer (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      in_tvalid,
  input  estmf_pkg::dp_flags_t     flags,
  output logic                     in_tready,
  output estmf_pkg::seq_ctrl_t     ctrl
);

  logic [estmf_pkg::STEP_W-1:0] step_r;
  logic [estmf_pkg::STEP_W-1:0] step_nxt;
  estmf_pkg::ucw_t              ucw;
  logic                         go;
  logic                         take;

  // Fetch the control word of the current step
  assign ucw = estmf_pkg::ucode(step_r);

  // Hold the step until its handshake is met
  always_comb begin
    unique case (ucw.wt)
      estmf_pkg::WT_NONE: go = 1'b1;
      estmf_pkg::WT_IN:   go = in_tvalid;
      estmf_pkg::WT_OUT:  go = flags.out_free;
      default:            go = 1'b0;
    endcase
  end

  // Evaluate the jump condition
  always_comb begin
    unique case (ucw.jc)
      estmf_pkg::JC_NEXT:      take = 1'b0;
      estmf_pkg::JC_ALWAYS:    take = 1'b1;
      estmf_pkg::JC_NO_SAMPLE: take = !flags.sample_due;
      estmf_pkg::JC_NOT_FULL:  take = flags.not_full;
      estmf_pkg::JC_SCAN_MORE: take = flags.scan_more;
      estmf_pkg::JC_DIV_MORE:  take = flags.div_more;
      default:                 take = 1'b0;
    endcase
  end

  // Advance or jump
  always_comb begin
    step_nxt = step_r;
    if (go) begin
      if (take) begin
        step_nxt = ucw.target;
      end else begin
        step_nxt = step_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= estmf_pkg::ST_ACCEPT;
    end else begin
      step_r <= step_nxt;
    end
  end

  assign in_tready = (ucw.wt == estmf_pkg::WT_IN);
  assign ctrl.op   = ucw.op;
  assign ctrl.fire = go;

endmodule

`default_nettype wire

// File: hw/rtl/estmf_datapath.sv
// Datapath: configuration, decimation, scaling, sample window, trimmed mean and low-pass.
`default_nettype none

module estmf_datapath (
  input  wire                      clk,
  input  wire                      rst_n,
  input  estmf_pkg::seq_ctrl_t     ctrl,
  input  wire                      cfg_valid,
  input  wire  [1:0]               cfg_index,
  input  wire  [31:0]              cfg_data,
  input  wire  [31:0]              in_tdata,
  input  wire                      out_tready,
  output estmf_pkg::dp_flags_t     flags,
  output logic                     out_tvalid,
  output logic [63:0]              out_tdata,   // speed_sample [31:0], filtered_speed [63:32]
  output logic [1:0]               out_tuser    // sample_taken [0], speed_updated [1]
);

  localparam int SW = estmf_pkg::SUM_W;
  localparam int DW = estmf_pkg::DIV_W;
  localparam int MW = estmf_pkg::MUL_W;
  localparam int IW = estmf_pkg::WIN_IW;
  localparam int CW = estmf_pkg::CNT_W;
  localparam logic signed [31:0] S32_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

  // Configuration
  logic [7:0]  period_r, period_nxt;
  logic [31:0] gain_r, gain_nxt;
  logic [16:0] alpha_r, alpha_nxt;

  // Channel state
  logic [7:0]        tick_r, tick_nxt;
  logic [31:0]       prev_r, prev_nxt;
  logic [IW-1:0]     fill_r, fill_nxt;
  logic signed [31:0] filt_r, filt_nxt;
  logic signed [31:0] win_r [estmf_pkg::WINDOW_SIZE];
  logic              win_we;

  // Working registers
  logic [31:0]                    pos_r, pos_nxt;
  logic signed [31:0]             diff_r, diff_nxt;
  logic signed [estmf_pkg::PROD_W-1:0] prod_r, prod_nxt;
  logic signed [estmf_pkg::RND_W-1:0]  rnd_r, rnd_nxt;
  logic signed [31:0]             sample_r, sample_nxt;
  logic                           taken_r, taken_nxt;
  logic                           updated_r, updated_nxt;
  logic [CW-1:0]                  cnt_r, cnt_nxt;
  logic signed [SW-1:0]           acc_r, acc_nxt;
  logic signed [31:0]             min1_r, min1_nxt, min2_r, min2_nxt;
  logic signed [31:0]             max1_r, max1_nxt, max2_r, max2_nxt;
  logic                           neg_r, neg_nxt;
  logic [DW-1:0]                  div_r, div_nxt;
  logic [3:0]                     rem_r, rem_nxt;
  logic [DW-1:0]                  quo_r, quo_nxt;
  logic signed [31:0]             avg_r, avg_nxt;
  logic signed [MW-1:0]           facc_r, facc_nxt;

  // Output stage
  logic        out_valid_r, out_valid_nxt;
  logic [63:0] out_data_r, out_data_nxt;
  logic [1:0]  out_user_r, out_user_nxt;

  // Shared multiplier and helpers
  logic signed [31:0]    mul_x;
  logic [16:0]           mul_y;
  logic signed [MW-1:0]  mul_p;
  logic [16:0]           alpha_sat;
  logic [16:0]           alpha_rest;
  logic signed [estmf_pkg::PROD_W-1:0] prod_sum;
  logic signed [MW-1:0]  facc_sum;
  logic signed [31:0]    rnd_sat;
  logic signed [31:0]    scan_v;
  logic signed [SW-1:0]  acc_mag;
  estmf_pkg::digit_t     digit;

  // Clamp the blend weight to one
  assign alpha_sat  = (alpha_r > 17'(estmf_pkg::ONE_Q16)) ? 17'(estmf_pkg::ONE_Q16) : alpha_r;
  assign alpha_rest = 17'(estmf_pkg::ONE_Q16) - alpha_sat;

  // Select multiplier operands by operation
  always_comb begin
    unique case (ctrl.op)
      estmf_pkg::OP_MUL_LO:   begin mul_x = diff_r; mul_y = {1'b0, gain_r[15:0]};  end
      estmf_pkg::OP_MUL_HI:   begin mul_x = diff_r; mul_y = {1'b0, gain_r[31:16]}; end
      estmf_pkg::OP_FMUL_NEW: begin mul_x = avg_r;  mul_y = alpha_sat;             end
      default:                begin mul_x = filt_r; mul_y = alpha_rest;            end
    endcase
  end

  assign mul_p = mul_x * $signed({1'b0, mul_y});

  // Round-to-nearest biases, ties away from zero
  assign prod_sum = prod_r + (prod_r[estmf_pkg::PROD_W-1] ? 64'sd32767 : 64'sd32768);
  assign facc_sum = facc_r + (facc_r[MW-1] ? MW'(32767) : MW'(32768));

  // Saturate the rounded sample to 32 bits
  always_comb begin
    if (rnd_r[estmf_pkg::RND_W-1:31] == '0 || rnd_r[estmf_pkg::RND_W-1:31] == '1) begin
      rnd_sat = rnd_r[31:0];
    end else if (rnd_r[estmf_pkg::RND_W-1]) begin
      rnd_sat = S32_MIN;
    end else begin
      rnd_sat = S32_MAX;
    end
  end

  assign scan_v  = win_r[cnt_r[IW-1:0]];
  assign acc_mag = acc_r[SW-1] ? -acc_r : acc_r;
  assign digit   = estmf_pkg::div_digit({rem_r, div_r[DW-1 -: 4]});

  // Next-state logic
  always_comb begin
    period_nxt  = period_r;
    gain_nxt    = gain_r;
    alpha_nxt   = alpha_r;
    tick_nxt    = tick_r;
    prev_nxt    = prev_r;
    fill_nxt    = fill_r;
    filt_nxt    = filt_r;
    win_we      = 1'b0;
    pos_nxt     = pos_r;
    diff_nxt    = diff_r;
    prod_nxt    = prod_r;
    rnd_nxt     = rnd_r;
    sample_nxt  = sample_r;
    taken_nxt   = taken_r;
    updated_nxt = updated_r;
    cnt_nxt     = cnt_r;
    acc_nxt     = acc_r;
    min1_nxt    = min1_r;
    min2_nxt    = min2_r;
    max1_nxt    = max1_r;
    max2_nxt    = max2_r;
    neg_nxt     = neg_r;
    div_nxt     = div_r;
    rem_nxt     = rem_r;
    quo_nxt     = quo_r;
    avg_nxt     = avg_r;
    facc_nxt    = facc_r;
    out_data_nxt  = out_data_r;
    out_user_nxt  = out_user_r;
    out_valid_nxt = out_valid_r & ~out_tready;

    // Take configuration writes
    if (cfg_valid) begin
      unique case (estmf_pkg::reg_idx_t'(cfg_index))
        estmf_pkg::REG_SAMPLE_PERIOD: period_nxt = cfg_data[7:0];
        estmf_pkg::REG_RPM_GAIN:      gain_nxt   = cfg_data;
        estmf_pkg::REG_FILTER_ALPHA:  alpha_nxt  = cfg_data[16:0];
        default: ;
      endcase
    end

    // Execute the current microcode step
    if (ctrl.fire) begin
      unique case (ctrl.op)
        estmf_pkg::OP_ACCEPT: begin
          pos_nxt     = in_tdata;
          diff_nxt    = in_tdata - prev_r;
          taken_nxt   = (tick_r == period_r);
          updated_nxt = 1'b0;
          sample_nxt  = '0;
        end
        estmf_pkg::OP_MUL_LO: begin
          prod_nxt = {{(estmf_pkg::PROD_W - MW){mul_p[MW-1]}}, mul_p};
        end
        estmf_pkg::OP_MUL_HI: begin
          prod_nxt = prod_r + {mul_p[47:0], 16'd0};
        end
        estmf_pkg::OP_ROUND: begin
          rnd_nxt = prod_sum[estmf_pkg::PROD_W-1:16];
        end
        estmf_pkg::OP_STORE: begin
          sample_nxt = rnd_sat;
          win_we     = 1'b1;
          prev_nxt   = pos_r;
          fill_nxt   = (fill_r == estmf_pkg::FILL_LAST) ? '0 : fill_r + 1'b1;
        end
        estmf_pkg::OP_SCAN_INIT: begin
          cnt_nxt  = '0;
          acc_nxt  = '0;
          min1_nxt = S32_MAX;
          min2_nxt = S32_MAX;
          max1_nxt = S32_MIN;
          max2_nxt = S32_MIN;
        end
        estmf_pkg::OP_SCAN: begin
          // Accumulate and track the two lowest and two highest samples
          acc_nxt = acc_r + {{(SW - 32){scan_v[31]}}, scan_v};
          if (scan_v < min1_r) begin
            min2_nxt = min1_r;
            min1_nxt = scan_v;
          end else if (scan_v < min2_r) begin
            min2_nxt = scan_v;
          end
          if (scan_v > max1_r) begin
            max2_nxt = max1_r;
            max1_nxt = scan_v;
          end else if (scan_v > max2_r) begin
            max2_nxt = scan_v;
          end
          cnt_nxt = cnt_r + 1'b1;
        end
        estmf_pkg::OP_TRIM_LO: begin
          acc_nxt = acc_r - {{(SW - 32){min1_r[31]}}, min1_r}
                          - {{(SW - 32){min2_r[31]}}, min2_r};
        end
        estmf_pkg::OP_TRIM_HI: begin
          acc_nxt = acc_r - {{(SW - 32){max1_r[31]}}, max1_r}
                          - {{(SW - 32){max2_r[31]}}, max2_r};
        end
        estmf_pkg::OP_ABS: begin
          neg_nxt = acc_r[SW-1];
          div_nxt = DW'(unsigned'(acc_mag)) + DW'(estmf_pkg::KEEP_COUNT / 2);
          rem_nxt = '0;
          cnt_nxt = '0;
        end
        estmf_pkg::OP_DIV: begin
          // One quotient digit per step, most significant first
          quo_nxt = {quo_r[DW-5:0], digit.q};
          rem_nxt = digit.r;
          div_nxt = {div_r[DW-5:0], 4'd0};
          cnt_nxt = cnt_r + 1'b1;
        end
        estmf_pkg::OP_AVG: begin
          if (neg_r) begin
            avg_nxt = (quo_r > DW'(64'h8000_0000)) ? S32_MIN : 32'(32'd0 - quo_r[31:0]);
          end else begin
            avg_nxt = (quo_r > DW'(64'h7fff_ffff)) ? S32_MAX : quo_r[31:0];
          end
        end
        estmf_pkg::OP_FMUL_NEW: begin
          facc_nxt = mul_p;
        end
        estmf_pkg::OP_FMUL_OLD: begin
          facc_nxt = facc_r + mul_p;
        end
        estmf_pkg::OP_FROUND: begin
          filt_nxt    = facc_sum[47:16];
          updated_nxt = 1'b1;
        end
        estmf_pkg::OP_EMIT: begin
          out_data_nxt  = {filt_r, sample_r};
          out_user_nxt  = {updated_r, taken_r};
          out_valid_nxt = 1'b1;
          tick_nxt      = taken_r ? 8'd1 : tick_r + 8'd1;
        end
      endcase
    end
  end

  // Control and channel state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r    <= 8'd5;
      gain_r      <= 32'd65536;
      alpha_r     <= 17'd31457;
      tick_r      <= '0;
      prev_r      <= '0;
      fill_r      <= '0;
      filt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      period_r    <= period_nxt;
      gain_r      <= gain_nxt;
      alpha_r     <= alpha_nxt;
      tick_r      <= tick_nxt;
      prev_r      <= prev_nxt;
      fill_r      <= fill_nxt;
      filt_r      <= filt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Working and payload registers
  always_ff @(posedge clk) begin
    pos_r      <= pos_nxt;
    diff_r     <= diff_nxt;
    prod_r     <= prod_nxt;
    rnd_r      <= rnd_nxt;
    sample_r   <= sample_nxt;
    taken_r    <= taken_nxt;
    updated_r  <= updated_nxt;
    cnt_r      <= cnt_nxt;
    acc_r      <= acc_nxt;
    min1_r     <= min1_nxt;
    min2_r     <= min2_nxt;
    max1_r     <= max1_nxt;
    max2_r     <= max2_nxt;
    neg_r      <= neg_nxt;
    div_r      <= div_nxt;
    rem_r      <= rem_nxt;
    quo_r      <= quo_nxt;
    avg_r      <= avg_nxt;
    facc_r     <= facc_nxt;
    out_data_r <= out_data_nxt;
    out_user_r <= out_user_nxt;
  end

  // Sample window, written at the fill index
  always_ff @(posedge clk) begin
    if (win_we) begin
      win_r[fill_r] <= rnd_sat;
    end
  end

  // Status to the sequencer
  assign flags.sample_due = (tick_r == period_r);
  assign flags.not_full   = (fill_r != estmf_pkg::FILL_LAST);
  assign flags.scan_more  = (cnt_r != estmf_pkg::SCAN_LAST);
  assign flags.div_more   = (cnt_r != estmf_pkg::DIV_LAST);
  assign flags.out_free   = !out_valid_r || out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

`default_nettype wire

// File: hw/rtl/encoder_speed_trimmed_mean_filter_core.sv
// Top level of the encoder speed estimator with trimmed-mean and low-pass filtering.
// Each input item is one tick carrying the extended encoder position; each tick gives one
// result item. Every sample_period ticks the position change is scaled by rpm_gain into a
// Q16.16 rpm sample and stored in a ten-entry window; when the window fills, the two lowest
// and two highest samples are dropped, the other six averaged and blended into the filtered
// speed with weight filter_alpha. A microcoded sequencer runs the datapath one step per
// cycle unless a step waits on a handshake: a plain tick runs accept and emit, a sample tick
// adds multiply, round and store, and the tick that completes the window adds scan, trim,
// divide, average and blend; the scan reads one window entry a cycle, the divider makes one
// radix-16 digit a cycle. A result waiting on out_tready adds its wait to the next item. The
// user writes configuration registers via the cfg channel while idle; the block does not check.
`default_nettype none

module encoder_speed_trimmed_mean_filter_core (
  input  wire         clk,
  input  wire         rst_n,
  // Configuration write channel
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [1:0]  cfg_index,
  input  wire  [31:0] cfg_data,
  // Tick items
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [31:0] in_tdata,    // position_count [31:0]
  // Result items
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [63:0] out_tdata,   // speed_sample [31:0], filtered_speed [63:32]
  output logic [1:0]  out_tuser    // sample_taken [0], speed_updated [1]
);

  estmf_pkg::seq_ctrl_t ctrl;
  estmf_pkg::dp_flags_t flags;

  // Registers accept a write every cycle
  assign cfg_ready = 1'b1;

  estmf_sequencer u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .flags     (flags),
    .in_tready (in_tready),
    .ctrl      (ctrl)
  );

  estmf_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl       (ctrl),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tdata   (in_tdata),
    .out_tready (out_tready),
    .flags      (flags),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

`default_nettype wire
